/* hdl/i2cee_pkg.sv */
// ----------------------------------------------------------------------------
// i2cee_pkg: shared types and constants
// Request codes, bus phases, register indexes and payload structs of the
// EEPROM I2C master.
// ----------------------------------------------------------------------------
package i2cee_pkg;

  localparam int MAX_BYTES = 64;
  localparam int BUF_AW    = $clog2(MAX_BYTES);
  localparam int LEN_W     = 7;
  localparam int TPQ_W     = 10;
  localparam int ATT_W     = 4;
  localparam int WAIT_W    = 24;
  localparam int CFG_IW    = 2;
  localparam int CFG_DW    = 24;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BYTES);

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  localparam logic [CFG_IW-1:0] CFG_TPQ      = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ATTEMPTS = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WWAIT    = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START,
    PH_TX_CTRL,
    PH_TX_AH,
    PH_TX_AL,
    PH_TX_DATA,
    PH_RSTART,
    PH_TX_RCTRL,
    PH_RX,
    PH_STOP,
    PH_WAIT
  } phase_t;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [7:0]       dev_control;
    logic [15:0]      mem_addr;
    logic             rw;
    logic [LEN_W-1:0] length;
    logic [7:0]       wdata;
    logic             sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       bus_enabled;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic       busy_res;
    logic       done_res;
    logic       failed;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] addr;
    logic [7:0]        data;
  } buf_wr_t;

endpackage

/* hdl/i2cee_ram.sv */
// ----------------------------------------------------------------------------
// i2cee_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module i2cee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/i2cee_skid.sv */
// ----------------------------------------------------------------------------
// i2cee_skid: result register with skid stage
// Holds results for the receiver; the skid entry takes one more request
// while the output register is stalled.
// ----------------------------------------------------------------------------
module i2cee_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  i2cee_pkg::out_item_t push_item,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cee_pkg::out_item_t out_item
);
  import i2cee_pkg::*;

  logic      skid_valid;
  out_item_t skid_item;
  logic      take;
  logic      load_out;

  assign take     = out_valid && !out_stall;
  assign load_out = !out_valid || take;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= skid_valid || push;
      end
      if (skid_valid && load_out) begin
        skid_valid <= 1'b0;
      end else if (push && !load_out) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_item <= skid_valid ? skid_item : push_item;
    end
    if (push && !load_out) begin
      skid_item <= push_item;
    end
  end

endmodule

/* hdl/i2cee_core.sv */
// ----------------------------------------------------------------------------
// i2cee_core: bus sequencer and bit timer
// Holds the request, times the quarter bits, shifts bytes on and off the
// bus and forms one result per request taken.
// ----------------------------------------------------------------------------
module i2cee_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  i2cee_pkg::in_item_t           item,
  input  logic                          cfg_we,
  input  logic [i2cee_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [i2cee_pkg::CFG_DW-1:0]  cfg_wdata,
  output i2cee_pkg::out_item_t          res,
  output i2cee_pkg::buf_wr_t            buf_wr,
  output logic [i2cee_pkg::BUF_AW-1:0]  buf_raddr,
  input  logic [7:0]                    buf_rdata
);
  import i2cee_pkg::*;

  // configuration
  logic [TPQ_W-1:0]  tpq;
  logic [ATT_W-1:0]  max_att;
  logic [WAIT_W-1:0] wwait;

  // sequencer state
  phase_t            phase, phase_next;
  logic [TPQ_W-1:0]  qcnt, qcnt_next;
  logic [1:0]        qidx, qidx_next;
  logic [3:0]        bit_count, bit_count_next;
  logic [LEN_W-1:0]  byte_index, byte_index_next;
  logic [ATT_W-1:0]  attempts_left, attempts_left_next;
  logic [7:0]        shift_reg, shift_reg_next;
  logic [WAIT_W-1:0] wait_count, wait_count_next;
  logic [7:0]        held_control, held_control_next;
  logic [15:0]       held_address, held_address_next;
  logic              held_rw, held_rw_next;
  logic [LEN_W-1:0]  held_len, held_len_next;

  logic              is_tx;
  logic              q_high;
  logic [TPQ_W-1:0]  tpq_eff;
  logic [WAIT_W-1:0] wc_inc;
  logic [LEN_W-1:0]  bi_inc;
  logic [7:0]        rx_shift;
  logic [LEN_W-1:0]  req_len;
  logic [LEN_W-1:0]  rd_addr_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      tpq     <= TPQ_W'(4);
      max_att <= ATT_W'(10);
      wwait   <= WAIT_W'(50000);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TPQ:      tpq     <= cfg_wdata[TPQ_W-1:0];
        CFG_ATTEMPTS: max_att <= cfg_wdata[ATT_W-1:0];
        CFG_WWAIT:    wwait   <= cfg_wdata[WAIT_W-1:0];
        default:      ;
      endcase
    end
  end

  assign is_tx   = (phase == PH_TX_CTRL) || (phase == PH_TX_AH) || (phase == PH_TX_AL) ||
                   (phase == PH_TX_DATA) || (phase == PH_TX_RCTRL);
  assign q_high  = (qidx == 2'd1) || (qidx == 2'd2);
  assign tpq_eff = (tpq == '0) ? TPQ_W'(1) : tpq;
  assign wc_inc  = wait_count + WAIT_W'(1);
  assign bi_inc  = byte_index + LEN_W'(1);
  assign rx_shift = {shift_reg[6:0], item.sda_in};

  // prefetch the buffer entry that the next data byte will need
  assign rd_addr_full = (phase == PH_TX_DATA) ? bi_inc : '0;
  assign buf_raddr    = rd_addr_full[BUF_AW-1:0];

  always_comb begin
    // pins show the levels held before this request
    res = '0;
    res.scl_level   = 1'b1;
    res.bus_enabled = 1'b1;
    case (phase)
      PH_IDLE, PH_WAIT: res.bus_enabled = 1'b0;
      PH_START, PH_RSTART: begin
        res.scl_level    = q_high;
        res.sda_pull_low = qidx[1];
      end
      PH_STOP: begin
        res.scl_level    = (qidx != 2'd0);
        res.sda_pull_low = !qidx[1];
      end
      PH_RX: begin
        res.scl_level    = q_high;
        res.sda_pull_low = (bit_count == 4'd8) && ({1'b0, byte_index} + 8'd1 < {1'b0, held_len});
      end
      PH_TX_CTRL, PH_TX_AH, PH_TX_AL, PH_TX_DATA, PH_TX_RCTRL: begin
        res.scl_level    = q_high;
        res.sda_pull_low = (bit_count < 4'd8) && !shift_reg[7];
      end
      default: res.bus_enabled = 1'b0;
    endcase

    phase_next         = phase;
    qcnt_next          = qcnt;
    qidx_next          = qidx;
    bit_count_next     = bit_count;
    byte_index_next    = byte_index;
    attempts_left_next = attempts_left;
    shift_reg_next     = shift_reg;
    wait_count_next    = wait_count;
    held_control_next  = held_control;
    held_address_next  = held_address;
    held_rw_next       = held_rw;
    held_len_next      = held_len;
    buf_wr.we          = 1'b0;
    buf_wr.addr        = byte_index[BUF_AW-1:0];
    buf_wr.data        = item.wdata;
    req_len            = '0;

    case (item.req_type)
      REQ_TICK: begin
        if (phase == PH_WAIT) begin
          wait_count_next = wc_inc;
          if (wc_inc >= wwait) begin
            res.done_res    = 1'b1;
            res.failed      = (attempts_left == '0);
            phase_next      = PH_IDLE;
            byte_index_next = '0;
          end
        end else if (phase != PH_IDLE) begin
          if ({1'b0, qcnt} + (TPQ_W+1)'(1) < {1'b0, tpq_eff}) begin
            qcnt_next = qcnt + TPQ_W'(1);
          end else begin
            qcnt_next = '0;
            if (qidx == 2'd2) begin
              // sample SDA with SCL high
              if (is_tx && bit_count == 4'd8) begin
                shift_reg_next = {7'd0, item.sda_in};
              end else if (phase == PH_RX && bit_count < 4'd8) begin
                shift_reg_next = rx_shift;
                if (bit_count == 4'd7) begin
                  res.read_valid = 1'b1;
                  res.read_byte  = rx_shift;
                  res.read_last  = ({1'b0, byte_index} + 8'd1 >= {1'b0, held_len});
                end
              end
            end
            if (qidx == 2'd3) begin
              qidx_next = 2'd0;
              // end of a bus bit
              if (phase == PH_START) begin
                phase_next     = PH_TX_CTRL;
                shift_reg_next = held_control & 8'hFE;
                bit_count_next = '0;
              end else if (phase == PH_RSTART) begin
                phase_next     = PH_TX_RCTRL;
                shift_reg_next = held_control | 8'h01;
                bit_count_next = '0;
              end else if (is_tx) begin
                if (bit_count < 4'd8) begin
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                  bit_count_next = bit_count + 4'd1;
                end else if (shift_reg[0]) begin
                  // NACK: retry from START or give up
                  attempts_left_next = (attempts_left != '0) ? attempts_left - ATT_W'(1) : '0;
                  byte_index_next    = '0;
                  bit_count_next     = '0;
                  phase_next         = (attempts_left_next == '0) ? PH_STOP : PH_START;
                end else begin
                  bit_count_next = '0;
                  case (phase)
                    PH_TX_CTRL: begin
                      phase_next     = PH_TX_AH;
                      shift_reg_next = held_address[15:8];
                    end
                    PH_TX_AH: begin
                      phase_next     = PH_TX_AL;
                      shift_reg_next = held_address[7:0];
                    end
                    PH_TX_AL: begin
                      byte_index_next = '0;
                      if (!held_rw) begin
                        phase_next = PH_RSTART;
                      end else if (held_len == '0) begin
                        phase_next = PH_STOP;
                      end else begin
                        phase_next     = PH_TX_DATA;
                        shift_reg_next = buf_rdata;
                      end
                    end
                    PH_TX_DATA: begin
                      byte_index_next = bi_inc;
                      if (bi_inc >= held_len) begin
                        phase_next = PH_STOP;
                      end else begin
                        shift_reg_next = buf_rdata;
                      end
                    end
                    default: begin
                      phase_next      = PH_RX;
                      byte_index_next = '0;
                      shift_reg_next  = '0;
                    end
                  endcase
                end
              end else if (phase == PH_RX) begin
                if (bit_count < 4'd8) begin
                  bit_count_next = bit_count + 4'd1;
                end else begin
                  byte_index_next = bi_inc;
                  bit_count_next  = '0;
                  shift_reg_next  = '0;
                  if (bi_inc >= held_len) begin
                    phase_next = PH_STOP;
                  end
                end
              end else if (phase == PH_STOP) begin
                if (held_rw && wwait != '0) begin
                  phase_next      = PH_WAIT;
                  wait_count_next = '0;
                end else begin
                  res.done_res    = 1'b1;
                  res.failed      = (attempts_left == '0);
                  phase_next      = PH_IDLE;
                  byte_index_next = '0;
                end
              end
            end else begin
              qidx_next = qidx + 2'd1;
            end
          end
        end
      end
      REQ_START: begin
        if (phase == PH_IDLE) begin
          req_len = (item.length > MAX_LEN) ? MAX_LEN : item.length;
          if (req_len == '0 && !item.rw) begin
            req_len = LEN_W'(1);
          end
          held_control_next  = item.dev_control;
          held_address_next  = item.mem_addr;
          held_rw_next       = item.rw;
          held_len_next      = req_len;
          attempts_left_next = (max_att == '0) ? ATT_W'(1) : max_att;
          phase_next         = PH_START;
          qcnt_next          = '0;
          qidx_next          = '0;
          bit_count_next     = '0;
          byte_index_next    = '0;
          shift_reg_next     = '0;
          wait_count_next    = '0;
        end
      end
      REQ_LOAD: begin
        if (phase == PH_IDLE && byte_index < MAX_LEN) begin
          buf_wr.we       = step;
          byte_index_next = bi_inc;
        end
      end
      default: ;
    endcase

    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      qcnt          <= '0;
      qidx          <= '0;
      bit_count     <= '0;
      byte_index    <= '0;
      attempts_left <= '0;
      shift_reg     <= '0;
      wait_count    <= '0;
      held_control  <= '0;
      held_address  <= '0;
      held_rw       <= 1'b0;
      held_len      <= '0;
    end else if (step) begin
      phase         <= phase_next;
      qcnt          <= qcnt_next;
      qidx          <= qidx_next;
      bit_count     <= bit_count_next;
      byte_index    <= byte_index_next;
      attempts_left <= attempts_left_next;
      shift_reg     <= shift_reg_next;
      wait_count    <= wait_count_next;
      held_control  <= held_control_next;
      held_address  <= held_address_next;
      held_rw       <= held_rw_next;
      held_len      <= held_len_next;
    end
  end

  a_rx_only: assert property (@(posedge clk) disable iff (rst)
    step && res.read_valid |-> phase == PH_RX)
    else $error("byte received outside the read phase");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> phase == PH_IDLE)
    else $error("request done but sequencer not idle");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    buf_wr.we |-> phase == PH_IDLE && byte_index < MAX_LEN)
    else $error("buffer written while busy or full");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    byte_index <= MAX_LEN)
    else $error("byte index beyond buffer");

  a_attempts_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_START || is_tx) |-> attempts_left != '0)
    else $error("transfer running with no attempts left");

endmodule

/* hdl/i2c_eeprom_master.sv */
// ----------------------------------------------------------------------------
// i2c_eeprom_master: I2C master for 16-bit addressed EEPROMs
// Random read and random write transactions, driven by bus tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_item carries one request: a bus tick (with the sampled SDA level),
//   a start request (control byte, address, direction, length) or a write
//   byte load. Load the write bytes first, then start, then feed ticks.
//   Every request taken yields exactly one out_item with the pin levels held
//   before it, any received byte, and busy/done/failed status.
//   A request is taken on each clock where in_valid is high and in_stall is
//   low; one request per clock is sustained while out_stall is low. Results
//   are registered in the result register, or in the skid entry while the
//   output is stalled. The two absorb a receiver stall: in_stall rises once
//   both hold a result, and nothing is lost or reordered.
//   The write buffer RAM is prefetched so a data byte is ready when the ACK
//   bit before it ends. Registers are written through cfg_we/cfg_index/cfg_wdata while
//   idle, which the user must keep to; the block does not enforce it. Reset returns the
//   sequencer to idle with the bus released, an empty buffer count and the default register values.
// ----------------------------------------------------------------------------
module i2c_eeprom_master (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  i2cee_pkg::in_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output i2cee_pkg::out_item_t          out_item,
  input  logic                          cfg_we,
  input  logic [i2cee_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [i2cee_pkg::CFG_DW-1:0]  cfg_wdata
);
  import i2cee_pkg::*;

  logic              step;
  out_item_t         res;
  buf_wr_t           buf_wr;
  logic [BUF_AW-1:0] buf_raddr;
  logic [7:0]        buf_rdata;

  assign step = in_valid && !in_stall;

  i2cee_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res),
    .buf_wr    (buf_wr),
    .buf_raddr (buf_raddr),
    .buf_rdata (buf_rdata)
  );

  i2cee_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_wbuf (
    .clk   (clk),
    .we    (buf_wr.we),
    .waddr (buf_wr.addr),
    .wdata (buf_wr.data),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  i2cee_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_item (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
